/* rtl/jpt_pkg.sv */
// Package for the JSON path tokenizer: beat types, codes, character constants and key classifiers.
package jpt_pkg;

   // Default depth of the queue between front and back. Must be 2 or more.
   localparam int QueueDepthDefault = 4;

   // Characters of the path grammar.
   localparam logic [7:0] CharDollar    = 8'h24;
   localparam logic [7:0] CharDot       = 8'h2E;
   localparam logic [7:0] CharOpen      = 8'h5B;
   localparam logic [7:0] CharClose     = 8'h5D;
   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharSquote    = 8'h27;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharColon     = 8'h3A;
   localparam logic [7:0] CharDash      = 8'h2D;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_END    = 2'd1,
      KIND_ACCEPT = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      MODE_ROOT   = 4'd0,
      MODE_SEG    = 4'd1,
      MODE_DOT    = 4'd2,
      MODE_BOPEN  = 4'd3,
      MODE_UNQ    = 4'd4,
      MODE_QUOTED = 4'd5,
      MODE_AFTERQ = 4'd6
   } mode_type;

   typedef struct packed {
      logic [7:0] path_byte;
      logic       end_of_path;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] token_byte;
      logic       run_last;
   } rsp_type;

   // Everything one input beat produces, in output order: key byte, token end, verdict.
   typedef struct packed {
      logic       has_byte;
      logic [7:0] token_byte;
      logic       has_end;
      logic       has_verdict;
      logic       accept;
   } entry_type;

   function automatic logic is_dot_key(input logic [7:0] c);
      return (c != CharOpen) && (c != CharDot) && (c != CharClose) &&
             (c != CharDquote) && (c != CharSquote) && (c != CharBackslash);
   endfunction

   function automatic logic is_unq_key(input logic [7:0] c);
      return (c != CharColon) && (c != CharDash) && is_dot_key(c);
   endfunction

endpackage

/* rtl/jpt_front.sv */
// Front end: parses one path byte per beat and classifies the results it causes.
module jpt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  jpt_pkg::req_type   req,
   output jpt_pkg::entry_type entry,
   output logic               entry_push
);
   import jpt_pkg::*;

   mode_type   mode_ff, mode_in, mode_mid;
   logic       quote_single_ff, quote_single_in;
   logic       escape_ff, escape_in;
   logic       nonempty_ff, nonempty_in, nonempty_mid;
   logic       failed_ff, failed_in, failed_mid;
   logic [7:0] c;
   logic [7:0] quote_char;
   logic       dot_key, unq_key;

   assign c          = req.path_byte;
   assign quote_char = quote_single_ff ? CharSquote : CharDquote;
   assign dot_key    = is_dot_key(c);
   assign unq_key    = is_unq_key(c);

   // Next state: effect of the byte, then the end-of-path clear.
   always_comb begin
      mode_mid        = mode_ff;
      quote_single_in = quote_single_ff;
      escape_in       = escape_ff;
      nonempty_mid    = nonempty_ff;
      failed_mid      = failed_ff;
      if (!failed_ff) begin
         unique case (mode_ff)
            MODE_ROOT: begin
               if (c == CharDollar) mode_mid = MODE_SEG;
               else failed_mid = 1'b1;
            end
            MODE_SEG: begin
               nonempty_mid = 1'b0;
               escape_in    = 1'b0;
               if (c == CharDot) mode_mid = MODE_DOT;
               else if (c == CharOpen) mode_mid = MODE_BOPEN;
               else failed_mid = 1'b1;
            end
            MODE_DOT: begin
               if (dot_key) begin
                  nonempty_mid = 1'b1;
               end else if (!nonempty_ff) begin
                  failed_mid = 1'b1;
               end else begin
                  nonempty_mid = 1'b0;
                  escape_in    = 1'b0;
                  if (c == CharDot) mode_mid = MODE_DOT;
                  else if (c == CharOpen) mode_mid = MODE_BOPEN;
                  else failed_mid = 1'b1;
               end
            end
            MODE_BOPEN: begin
               if (c == CharDquote || c == CharSquote) begin
                  quote_single_in = (c == CharSquote);
                  escape_in       = 1'b0;
                  nonempty_mid    = 1'b0;
                  mode_mid        = MODE_QUOTED;
               end else if (unq_key) begin
                  nonempty_mid = 1'b1;
                  mode_mid     = MODE_UNQ;
               end else begin
                  failed_mid = 1'b1;
               end
            end
            MODE_UNQ: begin
               if (unq_key) begin
                  mode_mid = MODE_UNQ;
               end else if (c == CharClose) begin
                  mode_mid     = MODE_SEG;
                  nonempty_mid = 1'b0;
               end else begin
                  failed_mid = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (escape_ff) begin
                  if (c == quote_char || c == CharBackslash) begin
                     nonempty_mid = 1'b1;
                     escape_in    = 1'b0;
                  end else begin
                     failed_mid = 1'b1;
                  end
               end else if (c == CharBackslash) begin
                  escape_in = 1'b1;
               end else if (c == quote_char) begin
                  if (nonempty_ff) mode_mid = MODE_AFTERQ;
                  else failed_mid = 1'b1;
               end else begin
                  nonempty_mid = 1'b1;
               end
            end
            MODE_AFTERQ: begin
               if (c == CharClose) begin
                  mode_mid     = MODE_SEG;
                  nonempty_mid = 1'b0;
               end else begin
                  failed_mid = 1'b1;
               end
            end
            default: failed_mid = 1'b1;
         endcase
      end

      mode_in     = mode_mid;
      nonempty_in = nonempty_mid;
      failed_in   = failed_mid;
      if (req.end_of_path) begin
         mode_in         = MODE_ROOT;
         quote_single_in = 1'b0;
         escape_in       = 1'b0;
         nonempty_in     = 1'b0;
         failed_in       = 1'b0;
      end
   end

   // Outputs: which results this byte causes.
   always_comb begin
      entry            = '0;
      entry.token_byte = c;
      if (!failed_ff) begin
         unique case (mode_ff)
            MODE_DOT: begin
               entry.has_byte = dot_key;
               entry.has_end  = !dot_key && nonempty_ff;
            end
            MODE_BOPEN:  entry.has_byte = unq_key && c != CharDquote && c != CharSquote;
            MODE_UNQ: begin
               entry.has_byte = unq_key;
               entry.has_end  = !unq_key && (c == CharClose);
            end
            MODE_QUOTED: begin
               if (escape_ff) entry.has_byte = (c == quote_char) || (c == CharBackslash);
               else entry.has_byte = (c != CharBackslash) && (c != quote_char);
            end
            MODE_AFTERQ: entry.has_end = (c == CharClose);
            default: entry.has_byte = 1'b0;
         endcase
      end
      if (req.end_of_path) begin
         entry.has_verdict = 1'b1;
         if (failed_mid) begin
            entry.accept = 1'b0;
         end else if (mode_mid == MODE_SEG) begin
            entry.accept = 1'b1;
         end else if (mode_mid == MODE_DOT && nonempty_mid) begin
            // A dot key still open at the end of the path is closed here.
            entry.has_end = 1'b1;
            entry.accept  = 1'b1;
         end else begin
            entry.accept = 1'b0;
         end
      end
   end

   assign entry_push = take && (entry.has_byte || entry.has_end || entry.has_verdict);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_ROOT;
         quote_single_ff <= 1'b0;
         escape_ff       <= 1'b0;
         nonempty_ff     <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (take) begin
         mode_ff         <= mode_in;
         quote_single_ff <= quote_single_in;
         escape_ff       <= escape_in;
         nonempty_ff     <= nonempty_in;
         failed_ff       <= failed_in;
      end
   end

endmodule

/* rtl/jpt_queue.sv */
// Short register queue of classified entries between the front and back ends.
module jpt_queue #(
   parameter int Depth = jpt_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jpt_pkg::entry_type push_entry,
   input  logic               pop,
   output jpt_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import jpt_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   entry_type            slot_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CntW'(Depth));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_pop  = pop && !empty;
   assign do_push = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/jpt_back.sv */
// Back end: unpacks queued entries into result beats through an output register.
module jpt_back (
   input  logic               clock,
   input  logic               reset,
   input  jpt_pkg::entry_type head,
   input  logic               head_valid,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output jpt_pkg::rsp_type   rsp_payload
);
   import jpt_pkg::*;

   // Bits in order: key byte, token end, verdict.
   logic [2:0] done_ff, done_in;
   logic [2:0] pending, pick;
   logic       valid_ff, valid_in;
   rsp_type    payload_ff, payload_in;
   logic       advance;

   assign pending = {head.has_byte, head.has_end, head.has_verdict} & ~done_ff;
   assign advance = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      priority if (pending[2]) pick = 3'b100;
      else if (pending[1]) pick = 3'b010;
      else pick = 3'b001;
   end

   always_comb begin
      done_in    = done_ff;
      valid_in   = valid_ff && rsp_stall;
      payload_in = payload_ff;
      head_pop   = 1'b0;
      if (advance) begin
         valid_in            = 1'b1;
         payload_in.run_last = ((pending & ~pick) == 3'b000);
         unique case (pick)
            3'b100: begin
               payload_in.kind       = KIND_BYTE;
               payload_in.token_byte = head.token_byte;
            end
            3'b010: begin
               payload_in.kind       = KIND_END;
               payload_in.token_byte = '0;
            end
            default: begin
               payload_in.kind       = head.accept ? KIND_ACCEPT : KIND_REJECT;
               payload_in.token_byte = '0;
            end
         endcase
         if (payload_in.run_last) begin
            head_pop = 1'b1;
            done_in  = '0;
         end else begin
            done_in = done_ff | pick;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

/* rtl/json_path_tokenizer.sv */
// Top level of the streaming JSON path tokenizer.
// The block reads a JSON path one byte per request beat, with end_of_path set on the
// final byte, and checks it against the grammar "$" followed by .key, [key], ['key']
// or ["key"] segments. Each request beat yields zero to three response beats: key
// bytes with escapes removed, a token-end beat after each key, and on the last byte a
// verdict of accepted or rejected; run_last marks the final response beat of a request
// beat. After the first error the rest of the path is ignored until its last byte,
// which gives the rejected verdict, and the block is then ready for the next path.
// A request beat is taken every cycle while the entry queue has room; the response
// side delivers one beat per cycle while rsp_stall is low, so a byte that yields
// several results occupies the output for one beat per result, and the queue of
// QueueDepth entries lets the parser run ahead of the output until it fills. A
// request reaches the output through a queue slot and then the output register.
module json_path_tokenizer #(
   parameter int QueueDepth = jpt_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jpt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jpt_pkg::rsp_type rsp_payload
);
   import jpt_pkg::*;

   entry_type entry, head;
   logic      entry_push, head_pop, head_empty, queue_full, take;

   // The parser only advances when its entry is sure to find room in the queue.
   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full;

   jpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req        (req_payload),
      .entry      (entry),
      .entry_push (entry_push)
   );

   jpt_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_push),
      .push_entry (entry),
      .pop        (head_pop),
      .head       (head),
      .empty      (head_empty),
      .full       (queue_full)
   );

   jpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (!head_empty),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
